// File: design/salc_pkg.sv
package salc_pkg;

  // Stream payload widths (fields packed from bit 0 up, padded to bytes)
  localparam int CMD_W        = 2;
  localparam int ADDR_FIELD_W = 64;
  localparam int IN_TDATA_W   = 72;
  localparam int OUTCOME_W    = 2;
  localparam int COUNT_W      = 32;
  localparam int OUT_TDATA_W  = 104;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SET_BITS_W = 3;
  localparam int BLK_BITS_W = 6;
  localparam int WAYS_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  // Widest set index the set_bits register can select
  localparam int SET_SPAN_W = (1 << SET_BITS_W) - 1;
  localparam int SET_SPAN   = 1 << SET_SPAN_W;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;  // unused code, handled as a load

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_MISS  = 2'd0,
    OUT_HIT   = 2'd1,
    OUT_EVICT = 2'd2,
    OUT_NONE  = 2'd3
  } outcome_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // take the input beat, read its set
    logic lookup;   // compare, update the set, bump totals
    logic second;   // second access of a modify
    logic emit;     // load the output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_modify;
    logic out_free;
  } dp_status_t;

endpackage

// File: design/set_assoc_lru_cache_tags.sv
// Channel    | Direction | Handshake                      | Payload
// s_axis     | in        | s_axis_tvalid / s_axis_tready  | tdata: command, address
// m_axis     | out       | m_axis_tvalid / m_axis_tready  | tdata: outcomes and totals
// cfg        | in        | cfg_we (no wait)               | cfg_index, cfg_data
//
// Sequence: an accepted beat passes LOOKUP, then SECOND for a modify only, then EMIT,
// which loads the result register; the next beat is taken only once back in IDLE.
// Reset: synchronous; per-set live flags are cleared so every set reads as
// empty at once, with no clearing pass. Config returns to 0, 0, 1 way.
// Stalls: a result waits in the output register; the next input beat is taken
// while it waits, and its own result holds in the datapath until the slot frees.
module set_assoc_lru_cache_tags #(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port: 0 set_bits, 1 block_bits, 2 ways_in_use
  input  logic                              cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input beats
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [1:0] command, [65:2] address, [71:66] zero
  input  logic [salc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Result beats
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] first_outcome, [3:2] second_outcome, [35:4] hit_count,
  // [67:36] miss_count, [99:68] eviction_count, [103:100] zero
  output logic [salc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import salc_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Sequence each beat: capture and read set, update, optional second access, emit
  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Set store, lookup and replacement, totals, result register
  salc_dpath #(
    .MAX_SETS   (MAX_SETS),
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: design/salc_ctrl.sv
module salc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  salc_pkg::dp_status_t  status,
  output salc_pkg::ctl_cmd_t    cmd
);
  import salc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SECOND,
    ST_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          state <= status.is_modify ? ST_SECOND : ST_EMIT;
        end
        ST_SECOND: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready    = (state == ST_IDLE);
  assign cmd.capture = (state == ST_IDLE) && in_valid;
  assign cmd.lookup  = (state == ST_LOOKUP);
  assign cmd.second  = (state == ST_SECOND);
  assign cmd.emit    = (state == ST_EMIT) && status.out_free;

endmodule

// File: design/salc_dpath.sv
module salc_dpath #(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [salc_pkg::IN_TDATA_W-1:0]    in_data,
  input  salc_pkg::ctl_cmd_t                 cmd,
  output salc_pkg::dp_status_t               status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [salc_pkg::OUT_TDATA_W-1:0]   out_data
);
  import salc_pkg::*;

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ACT_W  = $clog2(MAX_WAYS + 1) + 1;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);
  localparam int PAD_W  = OUT_TDATA_W - 2 * OUTCOME_W - 3 * COUNT_W;

  // Configuration
  logic [SET_BITS_W-1:0] set_bits;
  logic [BLK_BITS_W-1:0] block_bits;
  logic [WAYS_W-1:0]     ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= '0;
      block_bits  <= '0;
      ways_in_use <= WAYS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS:   set_bits    <= cfg_data[SET_BITS_W-1:0];
        CFG_BLOCK_BITS: block_bits  <= cfg_data[BLK_BITS_W-1:0];
        CFG_WAYS:       ways_in_use <= cfg_data[WAYS_W-1:0];
        default:        ;
      endcase
    end
  end

  // Set index folded onto the store, built at elaboration
  logic [SET_W-1:0] set_map [SET_SPAN];
  for (genvar g = 0; g < SET_SPAN; g++) begin : g_set_map
    assign set_map[g] = SET_W'(g % MAX_SETS);
  end

  // Address split
  logic [ADDR_WIDTH-1:0] addr_w;
  logic [ADDR_WIDTH-1:0] blk_shift;
  logic [SET_SPAN_W:0]   set_mask_ext;
  logic [SET_SPAN_W-1:0] set_raw;
  logic [6:0]            total_bits;
  logic [ADDR_WIDTH-1:0] tag_in;
  logic [SET_W-1:0]      row_idx;

  assign addr_w       = in_data[CMD_W +: ADDR_WIDTH];
  assign blk_shift    = addr_w >> block_bits;
  assign set_mask_ext = ((SET_SPAN_W + 1)'(1) << set_bits) - (SET_SPAN_W + 1)'(1);
  assign set_raw      = blk_shift[SET_SPAN_W-1:0] & set_mask_ext[SET_SPAN_W-1:0];
  assign total_bits   = 7'(set_bits) + 7'(block_bits);
  assign tag_in       = (total_bits >= 7'd64) ? '0 : (addr_w >> total_bits);
  assign row_idx      = set_map[set_raw];

  // Set store, one row per set
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem   [MAX_SETS];
  logic [MAX_WAYS-1:0][AGE_W-1:0]      age_mem   [MAX_SETS];
  logic [MAX_WAYS-1:0]                 valid_mem [MAX_SETS];
  logic [MAX_SETS-1:0]                 row_live;

  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_rd;
  logic [MAX_WAYS-1:0][AGE_W-1:0]      age_rd;
  logic [MAX_WAYS-1:0]                 valid_rd;
  logic                                live_q;
  logic [SET_W-1:0]                    row_q;
  logic [ADDR_WIDTH-1:0]               tag_q;
  logic                                modify_q;

  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_wr;
  logic [MAX_WAYS-1:0][AGE_W-1:0]      age_wr;
  logic [MAX_WAYS-1:0]                 valid_wr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tag_rd   <= tag_mem[row_idx];
      age_rd   <= age_mem[row_idx];
      valid_rd <= valid_mem[row_idx];
      row_q    <= row_idx;
      tag_q    <= tag_in;
      modify_q <= (in_data[CMD_W-1:0] == CMD_MODIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      tag_mem[row_q]   <= tag_wr;
      age_mem[row_q]   <= age_wr;
      valid_mem[row_q] <= valid_wr;
    end
  end

  // A row never written reads as all invalid, all rank zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_live <= '0;
      live_q   <= 1'b0;
    end else begin
      if (cmd.capture) live_q <= row_live[row_idx];
      if (cmd.lookup) row_live[row_q] <= 1'b1;
    end
  end

  // Lookup
  logic [ACT_W-1:0]                act_ways;
  logic [MAX_WAYS-1:0]             active;
  logic [MAX_WAYS-1:0]             valid_eff;
  logic [MAX_WAYS-1:0][AGE_W-1:0]  age_eff;
  logic [MAX_WAYS-1:0]             hit_vec;
  logic [MAX_WAYS-1:0]             inv_vec;
  logic [MAX_WAYS-1:0]             hit_first;
  logic [MAX_WAYS-1:0]             inv_first;
  logic [MAX_WAYS-1:0]             victim_vec;
  logic [MAX_WAYS-1:0]             sel;
  logic                            hit_any;
  logic                            inv_any;
  logic [AGE_W-1:0]                hit_age;
  logic [AGE_W:0]                  limit;

  always_comb begin
    if (ways_in_use == '0) begin
      act_ways = ACT_W'(1);
    end else if (ACT_W'(ways_in_use) > ACT_W'(MAX_WAYS)) begin
      act_ways = ACT_W'(MAX_WAYS);
    end else begin
      act_ways = ACT_W'(ways_in_use);
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      active[j]    = ACT_W'(j) < act_ways;
      valid_eff[j] = live_q & valid_rd[j];
      age_eff[j]   = live_q ? age_rd[j] : '0;
      hit_vec[j]   = active[j] & valid_eff[j] & (tag_rd[j] == tag_q);
      inv_vec[j]   = active[j] & ~valid_eff[j];
    end
  end

  assign hit_any   = |hit_vec;
  assign inv_any   = |inv_vec;
  assign hit_first = hit_vec & (~hit_vec + MAX_WAYS'(1));
  assign inv_first = inv_vec & (~inv_vec + MAX_WAYS'(1));

  // Oldest active way; lower index wins a tie
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      victim_vec[j] = active[j];
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (active[i] && i < j && !(age_eff[i] < age_eff[j])) victim_vec[j] = 1'b0;
        if (active[i] && i > j && !(age_eff[i] <= age_eff[j])) victim_vec[j] = 1'b0;
      end
    end
  end

  assign sel = hit_any ? hit_first : (inv_any ? inv_first : victim_vec);

  always_comb begin
    hit_age = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      hit_age = hit_age | (hit_first[j] ? age_eff[j] : '0);
    end
  end

  assign limit = hit_any ? {1'b0, hit_age} : (AGE_W + 1)'(MAX_WAYS);

  // New row: chosen way goes to rank zero, younger active ways age by one
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      tag_wr[j]   = tag_rd[j];
      valid_wr[j] = valid_eff[j];
      age_wr[j]   = age_eff[j];
      if (sel[j]) begin
        tag_wr[j]   = tag_q;
        valid_wr[j] = 1'b1;
        age_wr[j]   = '0;
      end else if (active[j] && ({1'b0, age_eff[j]} < limit) && (age_eff[j] != AGE_MAX)) begin
        age_wr[j] = age_eff[j] + AGE_W'(1);
      end
    end
  end

  // Totals and outcomes
  logic [COUNT_W-1:0] hits_total;
  logic [COUNT_W-1:0] misses_total;
  logic [COUNT_W-1:0] evictions_total;
  outcome_t           first_q;
  outcome_t           second_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_total      <= '0;
      misses_total    <= '0;
      evictions_total <= '0;
    end else if (cmd.lookup) begin
      if (hit_any) begin
        if (hits_total != '1) hits_total <= hits_total + COUNT_W'(1);
      end else begin
        if (misses_total != '1) misses_total <= misses_total + COUNT_W'(1);
        if (!inv_any && evictions_total != '1) begin
          evictions_total <= evictions_total + COUNT_W'(1);
        end
      end
    end else if (cmd.second) begin
      if (hits_total != '1) hits_total <= hits_total + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      first_q  <= hit_any ? OUT_HIT : (inv_any ? OUT_MISS : OUT_EVICT);
      second_q <= OUT_NONE;
    end else if (cmd.second) begin
      second_q <= OUT_HIT;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {PAD_W'(0), evictions_total, misses_total, hits_total, second_q, first_q};
    end
  end

  assign status.is_modify = modify_q;
  assign status.out_free  = !out_valid || out_ready;

  a_victim_onehot: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |-> $onehot(victim_vec) && $onehot(sel))
    else $error("replacement choice is not a single way");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hits_total >= $past(hits_total))
    else $error("hit total went backward");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && out_valid |-> out_ready)
    else $error("result register loaded while a beat is still pending");

  a_row_written_once: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |=> row_live[$past(row_q)])
    else $error("updated set not marked live");

endmodule
